[hw/rtl/lprle_pkg.sv]
// ----------------------------------------------------------------------------
// lprle_pkg
// Shared types and constants of the lossy pixel run-length encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package lprle_pkg;

  localparam int unsigned RunLimit  = 255;
  localparam int unsigned ThrWidth  = 10;
  localparam int unsigned QDepth    = 4;
  localparam int unsigned QPtrWidth = $clog2(QDepth);
  localparam int unsigned QCntWidth = $clog2(QDepth + 1);
  localparam logic [ThrWidth-1:0] ThrReset = ThrWidth'(10);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic       row_last;
    pixel_t     pix;
  } in_item_t;

  typedef struct packed {
    logic [7:0] length;
    pixel_t     pix;
    logic       row_end;
  } run_rec_t;

  // Records produced by one pixel step; second is only valid with the first
  typedef struct packed {
    logic     push0;
    logic     push1;
    run_rec_t rec0;
    run_rec_t rec1;
  } push_t;

endpackage

`default_nettype wire

[hw/rtl/lossy_pixel_run_length_encoder.sv]
// Path: a pixel's records pass the input register and the queue register
//   before they transfer out; a second record follows the first out.
// Throughput: one pixel per cycle while the output takes one record per
//   cycle; records leave one per cycle, so two-record pixels set the pace.
// Reset: asynchronous, active low; clears run state, queue pointers and
//   count and the input valid flag, and loads the threshold with 10.
// ----------------------------------------------------------------------------
// lossy_pixel_run_length_encoder
// Lossy run-length encoder for BGR pixels: input register, run step, queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lossy_pixel_run_length_encoder import lprle_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [ThrWidth-1:0] cfg_wdata_i,
  input  wire logic                in_valid_i,
  output      logic                in_stall_o,
  input  wire logic [7:0]          pixel_blue_i,
  input  wire logic [7:0]          pixel_green_i,
  input  wire logic [7:0]          pixel_red_i,
  input  wire logic                row_last_i,
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      logic [7:0]          run_length_o,
  output      logic [7:0]          run_blue_o,
  output      logic [7:0]          run_green_o,
  output      logic [7:0]          run_red_o,
  output      logic                row_end_o
);

  logic [ThrWidth-1:0]  thr_q;
  logic                 in_valid_q;
  in_item_t             in_item_q;
  logic                 step_go;
  logic                 in_take;
  logic                 pop;
  push_t                push;
  logic [QCntWidth-1:0] level;
  run_rec_t             head;

  // step only when the queue can absorb two records, counted before any pop
  assign step_go    = in_valid_q && (level <= QCntWidth'(QDepth - 2));
  assign in_stall_o = in_valid_q && !step_go;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take || step_go) begin
      in_valid_q <= in_take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q.pix.blue  <= pixel_blue_i;
      in_item_q.pix.green <= pixel_green_i;
      in_item_q.pix.red   <= pixel_red_i;
      in_item_q.row_last  <= row_last_i;
    end
  end

  lprle_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (step_go),
    .item_i (in_item_q),
    .thr_i  (thr_q),
    .push_o (push)
  );

  assign out_valid_o = (level != '0);
  assign pop         = out_valid_o && !out_stall_i;

  lprle_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .level_o (level),
    .head_o  (head)
  );

  assign run_length_o = head.length;
  assign run_blue_o   = head.pix.blue;
  assign run_green_o  = head.pix.green;
  assign run_red_o    = head.pix.red;
  assign row_end_o    = head.row_end;

  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level <= QCntWidth'(QDepth))
    else $error("result queue overflow");

  a_second_needs_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.push1 |-> (push.push0 && !push.rec0.row_end && push.rec1.row_end))
    else $error("second record without a mid-row break first");

  a_push_only_on_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.push0 |-> step_go)
    else $error("record pushed without a pixel step");

  a_length_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.push0 |-> (push.rec0.length != 8'd0))
    else $error("empty run emitted");

endmodule

`default_nettype wire

[hw/rtl/lprle_step.sv]
// ----------------------------------------------------------------------------
// lprle_step
// Run state and the per-pixel compare/count step; emits up to two records.
// ----------------------------------------------------------------------------
`default_nettype none

module lprle_step import lprle_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                go_i,
  input  wire in_item_t            item_i,
  input  wire logic [ThrWidth-1:0] thr_i,
  output      push_t               push_o
);

  pixel_t     held_q, held_d;
  logic [7:0] count_q, count_d;
  logic       open_q, open_d;

  logic [7:0] diff_b, diff_g, diff_r;
  logic [9:0] diff_sum;
  logic       close;
  logic       brk;
  logic [7:0] count_new;
  run_rec_t   brk_rec, last_rec;

  function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  always_comb begin
    diff_b   = abs_diff(item_i.pix.blue,  held_q.blue);
    diff_g   = abs_diff(item_i.pix.green, held_q.green);
    diff_r   = abs_diff(item_i.pix.red,   held_q.red);
    diff_sum = {2'b00, diff_b} + {2'b00, diff_g} + {2'b00, diff_r};
    close    = (diff_sum <= thr_i);

    brk       = 1'b0;
    count_new = 8'd1;
    if (open_q) begin
      if (close && (count_q < 8'(RunLimit))) begin
        count_new = count_q + 8'd1;
      end else begin
        brk = 1'b1;
      end
    end

    brk_rec.length   = count_q;
    brk_rec.pix      = held_q;
    brk_rec.row_end  = 1'b0;
    last_rec.length  = count_new;
    last_rec.pix     = item_i.pix;
    last_rec.row_end = 1'b1;

    push_o.push0 = go_i && (brk || item_i.row_last);
    push_o.push1 = go_i && brk && item_i.row_last;
    push_o.rec0  = brk ? brk_rec : last_rec;
    push_o.rec1  = last_rec;

    held_d  = held_q;
    count_d = count_q;
    open_d  = open_q;
    if (go_i) begin
      held_d = item_i.pix;
      if (item_i.row_last) begin
        count_d = 8'd0;
        open_d  = 1'b0;
      end else begin
        count_d = count_new;
        open_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= '0;
      count_q <= '0;
      open_q  <= 1'b0;
    end else begin
      held_q  <= held_d;
      count_q <= count_d;
      open_q  <= open_d;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/lprle_queue.sv]
// ----------------------------------------------------------------------------
// lprle_queue
// Small result queue; takes up to two records a cycle, gives one per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module lprle_queue import lprle_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire push_t                push_i,
  input  wire logic                 pop_i,
  output      logic [QCntWidth-1:0] level_o,
  output      run_rec_t             head_o
);

  run_rec_t               mem_q [QDepth];
  logic [QPtrWidth-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPtrWidth-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCntWidth-1:0]   cnt_q, cnt_d;
  logic [QPtrWidth-1:0]   wr_ptr_nx;

  always_comb begin
    wr_ptr_nx = wr_ptr_q + QPtrWidth'(1);
    wr_ptr_d  = wr_ptr_q + QPtrWidth'(push_i.push0) + QPtrWidth'(push_i.push1);
    rd_ptr_d  = rd_ptr_q + QPtrWidth'(pop_i);
    cnt_d     = cnt_q + QCntWidth'(push_i.push0) + QCntWidth'(push_i.push1)
              - QCntWidth'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push0) begin
      mem_q[wr_ptr_q] <= push_i.rec0;
    end
    if (push_i.push1) begin
      mem_q[wr_ptr_nx] <= push_i.rec1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  assign level_o = cnt_q;
  assign head_o  = mem_q[rd_ptr_q];

endmodule

`default_nettype wire
